### hdl/bnta_pkg.sv
// Package for the beacon neighbour table: controller states, status and
// register codes, and the command/status structs between controller and datapath.
// No dependencies.
package bnta_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_FILL,
    S_RESP
  } state_t;

  localparam logic [2:0] STAT_STORED = 3'd0;
  localparam logic [2:0] STAT_SHORT  = 3'd1;
  localparam logic [2:0] STAT_OWN    = 3'd2;
  localparam logic [2:0] STAT_FULL   = 3'd3;
  localparam logic [2:0] STAT_TIME   = 3'd4;

  localparam logic [2:0] REG_PAIRING   = 3'd0;
  localparam logic [2:0] REG_OWN_ID    = 3'd1;
  localparam logic [2:0] REG_TTL       = 3'd2;
  localparam logic [2:0] REG_BEACON_IV = 3'd3;
  localparam logic [2:0] REG_PURGE_IV  = 3'd4;

  localparam logic [31:0] TTL_RESET       = 32'd30000;
  localparam logic [31:0] BEACON_IV_RESET = 32'd2000;
  localparam logic [31:0] PURGE_IV_RESET  = 32'd5000;

  localparam logic [7:0] MIN_BEACON_LEN = 8'd5;

  typedef struct packed {
    logic load;
    logic eval;
    logic scan;
    logic fill;
    logic respond;
  } ctrl_t;

  typedef struct packed {
    logic need_scan;
    logic is_time;
    logic hit;
    logic last;
  } dp_stat_t;

endpackage

### hdl/bnta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bnta_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/bnta_ctrl.sv
// Controller state machine for the beacon neighbour table.
// Depends on bnta_pkg; drives the datapath through ctrl_t, reads dp_stat_t.
module bnta_ctrl
  import bnta_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output ctrl_t    ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = stat.need_scan ? S_SCAN : S_RESP;
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_next = S_RESP;
        end else if (stat.last) begin
          state_next = stat.is_time ? S_RESP : S_FILL;
        end
      end
      S_FILL: state_next = S_RESP;
      S_RESP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state != S_IDLE);
    ctrl.load    = (state == S_IDLE) && start;
    ctrl.eval    = (state == S_EVAL);
    ctrl.scan    = (state == S_SCAN);
    ctrl.fill    = (state == S_FILL);
    ctrl.respond = (state == S_RESP);
  end

endmodule

### hdl/bnta_dp.sv
// Datapath for the beacon neighbour table: configuration registers, item
// registers, valid bits, entry count, scan pipeline and result registers.
// Depends on bnta_pkg and bnta_ram.
module bnta_dp
  import bnta_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [2:0]                           cfg_index,
  input  logic [31:0]                          cfg_data,
  input  logic                                 cmd,
  input  logic [31:0]                          now_ms,
  input  logic [7:0]                           pkt_len,
  input  logic [31:0]                          sender_id,
  input  ctrl_t                                ctrl,
  output dp_stat_t                             stat,
  output logic                                 done,
  output logic [2:0]                           status,
  output logic                                 send_beacon,
  output logic                                 purged,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     entry_count
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_C  = (IDX_W+1)'(TABLE_DEPTH);

  logic        pairing_mode;
  logic [31:0] own_id;
  logic [31:0] ttl_ms;
  logic [31:0] beacon_gap_ms;
  logic [31:0] purge_interval_ms;

  logic        it_cmd;
  logic [31:0] it_now;
  logic [7:0]  it_len;
  logic [31:0] it_id;

  logic [31:0] last_beacon_ms;
  logic [31:0] last_purge_ms;

  logic [TABLE_DEPTH-1:0] valid;
  logic [CNT_W-1:0]       count;

  logic [IDX_W:0]   rd_cnt;
  logic             pipe_vld;
  logic [IDX_W-1:0] pipe_idx;
  logic             free_vld;
  logic [IDX_W-1:0] free_idx;

  logic [2:0] st;
  logic       send_flag;
  logic       purge_flag;

  logic        issue;
  logic        cur_valid;
  logic        hit;
  logic        stale;
  logic        bcn_short;
  logic        bcn_own;
  logic        beacon_due;
  logic        purge_due;
  logic [31:0] age;
  logic [31:0] rd_id;
  logic [31:0] rd_seen;
  logic [63:0] rd_word;
  logic        ram_we;
  logic [IDX_W-1:0] ram_waddr;

  bnta_ram #(
    .WIDTH(64),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({it_id, it_now}),
    .raddr(rd_cnt[IDX_W-1:0]),
    .rdata(rd_word)
  );

  always_comb begin
    rd_id      = rd_word[63:32];
    rd_seen    = rd_word[31:0];
    bcn_short  = (it_len < MIN_BEACON_LEN);
    bcn_own    = (it_id == own_id);
    beacon_due = ((it_now - last_beacon_ms) >= beacon_gap_ms);
    purge_due  = ((it_now - last_purge_ms) >= purge_interval_ms);
    issue      = ctrl.scan && (rd_cnt < DEPTH_C);
    cur_valid  = valid[pipe_idx];
    age        = it_now - rd_seen;
    hit        = ctrl.scan && pipe_vld && !it_cmd && cur_valid && (rd_id == it_id);
    stale      = ctrl.scan && pipe_vld && it_cmd && cur_valid && (age > ttl_ms);
    ram_we     = hit || (ctrl.fill && free_vld);
    ram_waddr  = hit ? pipe_idx : free_idx;

    stat.need_scan = it_cmd ? (pairing_mode && purge_due) : !(bcn_short || bcn_own);
    stat.is_time   = it_cmd;
    stat.hit       = hit;
    stat.last      = pipe_vld && (pipe_idx == LAST_IDX);
  end

  // configuration, table control and sequencing state
  always_ff @(posedge clk) begin
    if (rst) begin
      pairing_mode       <= 1'b0;
      own_id             <= '0;
      ttl_ms             <= TTL_RESET;
      beacon_gap_ms      <= BEACON_IV_RESET;
      purge_interval_ms  <= PURGE_IV_RESET;
      last_beacon_ms     <= '0;
      last_purge_ms      <= '0;
      valid              <= '0;
      count              <= '0;
      rd_cnt             <= '0;
      pipe_vld           <= 1'b0;
      free_vld           <= 1'b0;
      send_flag          <= 1'b0;
      purge_flag         <= 1'b0;
      done               <= 1'b0;
    end else begin
      done <= ctrl.respond;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PAIRING:   pairing_mode       <= cfg_data[0];
          REG_OWN_ID:    own_id             <= cfg_data;
          REG_TTL:       ttl_ms             <= cfg_data;
          REG_BEACON_IV: beacon_gap_ms      <= cfg_data;
          REG_PURGE_IV:  purge_interval_ms  <= cfg_data;
          default: ;
        endcase
      end
      if (ctrl.load) begin
        rd_cnt     <= '0;
        pipe_vld   <= 1'b0;
        free_vld   <= 1'b0;
        send_flag  <= 1'b0;
        purge_flag <= 1'b0;
      end
      if (ctrl.eval && it_cmd && pairing_mode) begin
        if (beacon_due) begin
          last_beacon_ms <= it_now;
          send_flag      <= 1'b1;
        end
        if (purge_due) begin
          last_purge_ms <= it_now;
          purge_flag    <= 1'b1;
        end
      end
      if (ctrl.scan) begin
        rd_cnt   <= rd_cnt + (IDX_W+1)'(issue);
        pipe_vld <= issue;
        if (pipe_vld && !cur_valid && !free_vld) begin
          free_vld <= 1'b1;
        end
        if (stale) begin
          valid[pipe_idx] <= 1'b0;
          count           <= count - CNT_W'(1);
        end
      end
      if (ctrl.fill && free_vld) begin
        valid[free_idx] <= 1'b1;
        count           <= count + CNT_W'(1);
      end
    end
  end

  // item, scan payload and result fields
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      it_cmd <= cmd;
      it_now <= now_ms;
      it_len <= pkt_len;
      it_id  <= sender_id;
    end
    if (ctrl.eval) begin
      if (it_cmd) begin
        st <= STAT_TIME;
      end else if (bcn_short) begin
        st <= STAT_SHORT;
      end else if (bcn_own) begin
        st <= STAT_OWN;
      end else begin
        st <= STAT_STORED;
      end
    end
    if (ctrl.scan) begin
      pipe_idx <= rd_cnt[IDX_W-1:0];
      if (pipe_vld && !cur_valid && !free_vld) begin
        free_idx <= pipe_idx;
      end
    end
    if (ctrl.fill && !free_vld) begin
      st <= STAT_FULL;
    end
    if (ctrl.respond) begin
      status      <= st;
      send_beacon <= send_flag;
      purged      <= purge_flag;
      entry_count <= count;
    end
  end

endmodule

### hdl/beacon_neighbor_table_aging.sv
// Beacon neighbour table with aging: top level joining controller and datapath.
// Depends on bnta_pkg, bnta_ctrl, bnta_dp, bnta_ram.
// An ignored beacon or a time check without purge goes from accept through EVAL and RESP to done;
// a table scan adds SCAN, reading the table RAM one entry per cycle, and FILL for a new entry.
// A new transaction is taken in the done cycle.
// Reset clears valid bits, entry count, timers and config registers; the receiver cannot stall.
module beacon_neighbor_table_aging
  import bnta_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cmd,
  input  logic [31:0]                      now_ms,
  input  logic [7:0]                       pkt_len,
  input  logic [31:0]                      sender_id,
  output logic                             done,
  output logic [2:0]                       status,
  output logic                             send_beacon,
  output logic                             purged,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [2:0]                       cfg_index,
  input  logic [31:0]                      cfg_data
);

  ctrl_t    ctrl;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bnta_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .ctrl (ctrl)
  );

  bnta_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .now_ms     (now_ms),
    .pkt_len    (pkt_len),
    .sender_id  (sender_id),
    .ctrl       (ctrl),
    .stat       (stat),
    .done       (done),
    .status     (status),
    .send_beacon(send_beacon),
    .purged     (purged),
    .entry_count(entry_count)
  );

endmodule

### hdl/bnta_checker.sv
// Port-level checks for the beacon neighbour table, bound to the top level.
// Depends on bnta_pkg and beacon_neighbor_table_aging.
module bnta_checker
  import bnta_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic [2:0]                       status,
  input logic                             send_beacon,
  input logic                             purged,
  input logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  a_flags_time_only: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STAT_TIME)) |-> (!send_beacon && !purged))
    else $error("beacon or purge flag on a beacon result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_count <= CNT_W'(TABLE_DEPTH)))
    else $error("entry count above table depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_FULL)) |-> (entry_count == CNT_W'(TABLE_DEPTH)))
    else $error("table full reported with free entries");

endmodule

bind beacon_neighbor_table_aging bnta_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_bnta_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .send_beacon(send_beacon),
  .purged     (purged),
  .entry_count(entry_count)
);

### sim/tb_beacon_neighbor_table_aging.sv
`timescale 1ns / 1ps
// Testbench for beacon_neighbor_table_aging: directed and random beacons and time checks,
// each result checked against an in-bench model of the neighbour table and its timers.
// Depends on bnta_pkg and the RTL of the block.
module tb_beacon_neighbor_table_aging;
  import bnta_pkg::*;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [2:0] REG_SPARE = 3'd5;
  localparam logic CMD_BEACON = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = DEPTH + 8;
  localparam int POOL_SIZE = 24;

  typedef struct packed {
    logic        cmd;
    logic [31:0] now;
    logic [7:0]  len;
    logic [31:0] sid;
  } item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             send;
    logic             purged;
    logic [CNT_W-1:0] count;
  } outcome_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             cmd = 1'b0;
  logic [31:0]      now_ms = '0;
  logic [7:0]       pkt_len = '0;
  logic [31:0]      sender_id = '0;
  logic             done;
  logic [2:0]       status;
  logic             send_beacon;
  logic             purged;
  logic [CNT_W-1:0] entry_count;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [2:0]       cfg_index = '0;
  logic [31:0]      cfg_data = '0;

  // neighbour table model
  logic        nb_valid [DEPTH];
  logic [31:0] nb_id [DEPTH];
  logic [31:0] nb_seen [DEPTH];
  logic [31:0] last_beacon, last_purge;
  logic        pairing_on;
  logic [31:0] own_node, ttl_lim, beacon_gap, purge_gap;

  outcome_t    awaited_outcomes[$];
  outcome_t    got_o, want_o;
  logic [31:0] id_pool [POOL_SIZE];
  logic [31:0] cur_ms;
  int          gap_pct = 0;
  int          mismatches = 0;
  int          items_sent = 0;
  int          status_tally [5];
  int          beacon_requests = 0;
  int          purge_runs = 0;
  int unsigned cycle_count = 0;

  beacon_neighbor_table_aging #(.TABLE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .now_ms(now_ms),
    .pkt_len(pkt_len), .sender_id(sender_id), .done(done), .status(status),
    .send_beacon(send_beacon), .purged(purged), .entry_count(entry_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic outcome_t table_step(input item_t it);
    outcome_t    o;
    int          free_slot;
    logic        hit;
    logic [31:0] age;
    o = '0;
    if (it.cmd == CMD_BEACON) begin
      if (it.len < MIN_BEACON_LEN) begin
        o.status = STAT_SHORT;
      end else if (it.sid == own_node) begin
        o.status = STAT_OWN;
      end else begin
        free_slot = -1;
        hit = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
          if (nb_valid[i]) begin
            if (!hit && nb_id[i] == it.sid) begin
              nb_seen[i] = it.now;
              hit = 1'b1;
            end
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit) begin
          o.status = STAT_STORED;
        end else if (free_slot < 0) begin
          o.status = STAT_FULL;
        end else begin
          nb_valid[free_slot] = 1'b1;
          nb_id[free_slot] = it.sid;
          nb_seen[free_slot] = it.now;
          o.status = STAT_STORED;
        end
      end
    end else begin
      o.status = STAT_TIME;
      if (pairing_on) begin
        age = it.now - last_beacon;
        if (age >= beacon_gap) begin
          last_beacon = it.now;
          o.send = 1'b1;
        end
        age = it.now - last_purge;
        if (age >= purge_gap) begin
          last_purge = it.now;
          o.purged = 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            age = it.now - nb_seen[i];
            if (nb_valid[i] && age > ttl_lim) nb_valid[i] = 1'b0;
          end
        end
      end
    end
    for (int i = 0; i < DEPTH; i++) o.count += CNT_W'(nb_valid[i]);
    return o;
  endfunction

  task automatic log_mismatch(input string what, input outcome_t want, input outcome_t got);
    string want_s;
    string got_s;
    mismatches++;
    if (mismatches <= 10) begin
      want_s = $sformatf("status %0d send %0b purged %0b count %0d",
                         want.status, want.send, want.purged, want.count);
      got_s = $sformatf("status %0d send %0b purged %0b count %0d",
                        got.status, got.send, got.purged, got.count);
      $display("%0t %s: expected %s, got %s", $realtime, what, want_s, got_s);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      got_o.status = status;
      got_o.send = send_beacon;
      got_o.purged = purged;
      got_o.count = entry_count;
      if (awaited_outcomes.size() == 0) begin
        log_mismatch("unexpected result", '0, got_o);
      end else begin
        want_o = awaited_outcomes.pop_front();
        if (got_o.status !== want_o.status || got_o.send !== want_o.send ||
            got_o.purged !== want_o.purged || got_o.count !== want_o.count)
          log_mismatch("result mismatch", want_o, got_o);
      end
    end
  end

  task automatic send_item(input logic c, input logic [31:0] t, input logic [7:0] l,
                           input logic [31:0] s);
    item_t    it;
    outcome_t o;
    it = '{cmd: c, now: t, len: l, sid: s};
    while ($urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    now_ms <= t;
    pkt_len <= l;
    sender_id <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    o = table_step(it);
    awaited_outcomes.insert(awaited_outcomes.size(), o);
    items_sent++;
    status_tally[o.status]++;
    beacon_requests += o.send;
    purge_runs += o.purged;
  endtask

  // hold start low and wait for the block to go quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_outcomes.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PAIRING:   pairing_on = val[0];
      REG_OWN_ID:    own_node = val;
      REG_TTL:       ttl_lim = val;
      REG_BEACON_IV: beacon_gap = val;
      REG_PURGE_IV:  purge_gap = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_ignored_beacons();
    send_item(CMD_BEACON, 32'd0, 8'd0, 32'd1);
    send_item(CMD_BEACON, 32'd3, 8'd4, 32'd2);
    send_item(CMD_BEACON, 32'd7, 8'd5, 32'd0);
    send_item(CMD_BEACON, 32'd9, 8'hFF, 32'hFFFF_FFFF);
    send_item(CMD_BEACON, 32'hFFFF_FFFF, 8'd5, 32'hFFFF_FFFF);
    send_item(CMD_TICK, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_table_fill();
    settle();
    write_reg(REG_OWN_ID, 32'hFFFF_FFFF);
    for (int i = 1; i < DEPTH; i++)
      send_item(CMD_BEACON, 32'd1000 + i, 8'(5 + i), 32'h1000_0000 + i);
    send_item(CMD_BEACON, 32'd1050, 8'd6, 32'h2000_0000);
    send_item(CMD_BEACON, 32'd1051, 8'd6, 32'hFFFF_FFFF);
  endtask

  task automatic test_time_checks();
    settle();
    write_reg(REG_PAIRING, 32'hFFFF_FFFF);
    write_reg(REG_TTL, 32'd100);
    write_reg(REG_BEACON_IV, 32'd1105);
    write_reg(REG_PURGE_IV, 32'd1000);
    send_item(CMD_TICK, 32'd1105, 8'd0, 32'd0);
    send_item(CMD_TICK, 32'd1106, 8'd0, 32'd0);
    send_item(CMD_TICK, 32'd16, 8'd0, 32'd0);
    settle();
    write_reg(REG_BEACON_IV, 32'd0);
    write_reg(REG_PURGE_IV, 32'd0);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_item(CMD_TICK, 32'd16, 8'd0, 32'd0);
    settle();
    write_reg(REG_TTL, 32'hFFFF_FFFF);
    write_reg(REG_BEACON_IV, 32'hFFFF_FFFF);
    write_reg(REG_PURGE_IV, 32'hFFFF_FFFF);
    send_item(CMD_BEACON, 32'd20, 8'd9, 32'h0000_0001);
    send_item(CMD_TICK, 32'd15, 8'd0, 32'd0);
    send_item(CMD_TICK, 32'd16, 8'd0, 32'd0);
  endtask

  function automatic logic [31:0] pick_span(input logic [31:0] lo, input logic [31:0] hi);
    case ($urandom_range(5, 0))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  task automatic test_random_traffic(input int pct, input int n);
    logic [31:0] word, step_max, now_v, sid_v;
    logic [7:0]  len_v;
    logic        cmd_v;
    settle();
    gap_pct = pct;
    word = $urandom();
    word[0] = ($urandom_range(7, 0) != 0);
    write_reg(REG_PAIRING, word);
    case ($urandom_range(3, 0))
      0:       word = 32'd0;
      1:       word = 32'hFFFF_FFFF;
      default: word = $urandom();
    endcase
    write_reg(REG_OWN_ID, word);
    write_reg(REG_TTL, pick_span(32'd500, 32'd20000));
    write_reg(REG_BEACON_IV, pick_span(32'd100, 32'd5000));
    write_reg(REG_PURGE_IV, pick_span(32'd100, 32'd5000));
    step_max = $urandom_range(1500, 50);
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(29, 0) == 0) cur_ms = $urandom();
      else cur_ms = cur_ms + $urandom_range(step_max, 0);
      now_v = cur_ms;
      cmd_v = ($urandom_range(3, 0) == 0) ? CMD_TICK : CMD_BEACON;
      if (cmd_v == CMD_TICK) begin
        len_v = 8'($urandom());
        sid_v = $urandom();
      end else begin
        len_v = ($urandom_range(99, 0) < 85) ? 8'($urandom_range(255, 5))
                                             : 8'($urandom_range(4, 0));
        case ($urandom_range(24, 0))
          0, 1:    sid_v = own_node;
          2, 3, 4: sid_v = $urandom();
          default: sid_v = id_pool[$urandom_range(POOL_SIZE - 1, 0)];
        endcase
      end
      send_item(cmd_v, now_v, len_v, sid_v);
    end
  endtask

  initial begin
    pairing_on = 1'b0;
    own_node = '0;
    ttl_lim = TTL_RESET;
    beacon_gap = BEACON_IV_RESET;
    purge_gap = PURGE_IV_RESET;
    last_beacon = '0;
    last_purge = '0;
    cur_ms = $urandom();
    for (int i = 0; i < DEPTH; i++) begin
      nb_valid[i] = 1'b0;
      nb_id[i] = '0;
      nb_seen[i] = '0;
    end
    for (int i = 0; i < 5; i++) status_tally[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ignored_beacons();
    test_table_fill();
    test_time_checks();
    test_random_traffic(25, 100);
    test_random_traffic(25, 100);
    test_random_traffic(53, 100);
    test_random_traffic(53, 100);
    test_random_traffic(0, 100);
    test_random_traffic(0, 100);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d transactions: %0d stored, %0d short, %0d own id, %0d full, %0d ticks",
             items_sent, status_tally[STAT_STORED], status_tally[STAT_SHORT],
             status_tally[STAT_OWN], status_tally[STAT_FULL], status_tally[STAT_TIME]);
    $display("Time checks raised %0d beacon requests and %0d purges; %0d mismatches",
             beacon_requests, purge_runs, mismatches);
    if (mismatches == 0 && awaited_outcomes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/bnta_pkg.sv
hdl/bnta_ram.sv
hdl/bnta_ctrl.sv
hdl/bnta_dp.sv
hdl/beacon_neighbor_table_aging.sv
hdl/bnta_checker.sv
sim/tb_beacon_neighbor_table_aging.sv
